FILE: sv/feds_pkg.sv
// Shared types, constants and helper functions for the field energy density
// stencil unit. No dependencies; the front end, queue, back end and top use it.

package feds_pkg;

   localparam int FIELD_COUNT = 3;
   localparam int WORD_W      = 32;
   localparam int CFG_W       = 31;
   localparam int OUT_W       = 40;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_POT_MU     = 2'd0;
   localparam logic [1:0] CSR_POT_KAPPA  = 2'd1;
   localparam logic [1:0] CSR_MASS_SQ    = 2'd2;
   localparam logic [1:0] CSR_INV_TWO_DX = 2'd3;

   // register reset values
   localparam logic [31:0] RST_POT_MU     = 32'hEC00_0000;
   localparam logic [30:0] RST_POT_KAPPA  = 31'd335544320;
   localparam logic [30:0] RST_MASS_SQ    = 31'd16777216;
   localparam logic [30:0] RST_INV_TWO_DX = 31'd167730217;

   // per-term clamp and output limits
   localparam logic [63:0] TERM_LIM = 64'h0400_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HALF_LIM = 64'h8000_0000_0000_0000;
   localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
   localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [31:0] mu;
      logic [30:0] kappa;
      logic [30:0] mass;
      logic [30:0] inv;
   } cfg_type;

   // one unit of work for the back end
   typedef struct packed {
      word_type [FIELD_COUNT-1:0] prev;
      word_type [FIELD_COUNT-1:0] cen;
      word_type [FIELD_COUNT-1:0] next;
      word_type [FIELD_COUNT-1:0] spd;
      logic                       has_main;
      logic                       is_dens;
      logic                       has_final;
   } job_type;

   // magnitude of a signed word
   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   // magnitude of the difference of two signed words
   function automatic logic [32:0] mag_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      mag_diff = d[32] ? (33'd0 - d) : d;
   endfunction

   // floor shift of a full product, limited to lim
   function automatic logic [63:0] shr_sat(input logic [127:0] p, input int unsigned sh,
                                           input logic [63:0] lim);
      logic [127:0] r;
      r = p >> sh;
      shr_sat = (r[127:64] != 64'd0 || r[63:0] > lim) ? lim : r[63:0];
   endfunction

endpackage

FILE: sv/feds_front.sv
// Front end: accepts grid points, keeps the three-point window and classifies
// each point into a job for the back end. Depends on feds_pkg.

module feds_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [191:0]       req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output feds_pkg::job_type  q_job
);

   feds_pkg::word_type [feds_pkg::FIELD_COUNT-1:0] prev_ff, prev_in;
   feds_pkg::word_type [feds_pkg::FIELD_COUNT-1:0] cen_ff, cen_in;
   feds_pkg::word_type [feds_pkg::FIELD_COUNT-1:0] spd_ff, spd_in;
   feds_pkg::word_type [feds_pkg::FIELD_COUNT-1:0] cur_fld;
   feds_pkg::word_type [feds_pkg::FIELD_COUNT-1:0] cur_spd;
   logic [1:0] seen_ff, seen_in;
   logic       take;

   assign req_tready = !q_full;
   assign take       = req_tvalid && !q_full;

   // unpack: fields first, then speeds
   assign cur_fld = req_tdata[95:0];
   assign cur_spd = req_tdata[191:96];

   // classify and shift the window
   always_comb begin
      prev_in = prev_ff;
      cen_in  = cen_ff;
      spd_in  = spd_ff;
      seen_in = seen_ff;
      q_job.prev      = prev_ff;
      q_job.cen       = cen_ff;
      q_job.next      = cur_fld;
      q_job.spd       = spd_ff;
      q_job.has_main  = 1'b0;
      q_job.is_dens   = 1'b0;
      q_job.has_final = req_tlast;
      if (take) begin
         prev_in = cen_ff;
         cen_in  = cur_fld;
         spd_in  = cur_spd;
         unique case (seen_ff)
            2'd0: seen_in = 2'd1;
            2'd1: begin
               seen_in        = 2'd2;
               q_job.has_main = 1'b1;
            end
            default: begin
               q_job.has_main = 1'b1;
               q_job.is_dens  = 1'b1;
            end
         endcase
         if (req_tlast) begin
            prev_in = '0;
            cen_in  = '0;
            spd_in  = '0;
            seen_in = 2'd0;
         end
      end
      q_push = take && (q_job.has_main || q_job.has_final);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         cen_ff  <= '0;
         spd_ff  <= '0;
         seen_ff <= 2'd0;
      end else begin
         prev_ff <= prev_in;
         cen_ff  <= cen_in;
         spd_ff  <= spd_in;
         seen_ff <= seen_in;
      end
   end

endmodule

FILE: sv/feds_queue.sv
// Two-entry job queue between front and back end.
// Depends on feds_pkg.

module feds_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  feds_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output feds_pkg::job_type head_job
);

   feds_pkg::job_type mem_ff [feds_pkg::QUEUE_DEPTH];
   logic [feds_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [feds_pkg::QCNT_W-1:0] cnt_ff;

   assign full       = (cnt_ff == feds_pkg::QCNT_W'(feds_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

endmodule

FILE: sv/feds_mul.sv
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier,
// four partial products over successive cycles. No dependencies.

module feds_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   opa,
   input  logic [63:0]   opb,
   output logic          done,
   output logic [127:0]  prod
);

   logic [63:0]  a_ff, b_ff;
   logic [1:0]   cnt_ff;
   logic         busy_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pp_sh_ff;
   logic         pp_vld_ff, pp_last_ff;
   logic         done_ff;
   logic [127:0] acc_ff;
   logic [31:0]  ai, bj;

   assign ai   = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign bj   = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign done = done_ff;
   assign prod = acc_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= 2'd0;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff    <= pp_vld_ff && pp_last_ff;
         pp_vld_ff  <= busy_ff;
         pp_last_ff <= busy_ff && (cnt_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) busy_ff <= 1'b0;
         end
      end
   end

   // datapath: partial product, then shifted accumulate
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= opa;
         b_ff   <= opb;
         acc_ff <= '0;
      end else if (pp_vld_ff) begin
         unique case (pp_sh_ff)
            2'd0:    acc_ff <= acc_ff + {64'd0, pp_ff};
            2'd1:    acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
            default: acc_ff <= acc_ff + {pp_ff, 64'd0};
         endcase
      end
      pp_ff    <= ai * bj;
      pp_sh_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
   end

endmodule

FILE: sv/feds_div.sv
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit
// per cycle; keeps the low 64 quotient bits. No dependencies.

module feds_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num_hi,
   input  logic [63:0] num_lo,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic [127:0] dvd_ff;
   logic [63:0]  den_ff, rem_ff, quo_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [63:0]  rem_sh;
   logic         take;

   assign rem_sh = {rem_ff[62:0], dvd_ff[127]};
   assign take   = rem_ff[63] || (rem_sh >= den_ff);
   assign done   = done_ff;
   assign quo    = quo_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd127);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) busy_ff <= 1'b0;
         end
      end
   end

   // one shift-subtract step
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num_hi, num_lo};
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[126:0], 1'b0};
         rem_ff <= take ? (rem_sh - den_ff) : rem_sh;
         quo_ff <= {quo_ff[62:0], take};
      end
   end

endmodule

FILE: sv/feds_back.sv
// Back end: sequences the density terms through the shared multiplier and the
// divider and drives the result register. Depends on feds_pkg, feds_mul, feds_div.

module feds_back #(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  feds_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  feds_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_KIN, ST_GRD1, ST_GRD2, ST_MAS1, ST_MAS2,
      ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_DIV, ST_MAIN, ST_FINAL
   } state_type;

   state_type         state_ff, state_in;
   feds_pkg::job_type job_ff, job_in;
   logic [1:0]        lane_ff, lane_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       tmp_ff, tmp_in;
   logic [63:0]       s_ff, s_in;
   logic [63:0]       den_ff, den_in;
   logic [63:0]       num_ff, num_in;
   logic              wait_ff, wait_in;
   logic              vld_ff, vld_in;
   logic [39:0]       data_ff, data_in;
   logic              last_ff, last_in;

   logic [63:0]  mul_a, mul_b;
   logic         mul_start, mul_done;
   logic [127:0] prod;
   logic         div_start, div_done;
   logic [63:0]  quo;
   logic         mul_state, out_free;
   logic [63:0]  q_lim;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   feds_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .opa   (mul_a),
      .opb   (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   feds_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (num_ff >> (64 - FRAC_BITS)),
      .num_lo (num_ff << FRAC_BITS),
      .den    (den_ff),
      .done   (div_done),
      .quo    (quo)
   );

   // saturate the accumulator to the output range
   function automatic logic [39:0] sat_out(input logic [63:0] a);
      if ($signed(a) > feds_pkg::OUT_MAX)      sat_out = feds_pkg::OUT_MAX[39:0];
      else if ($signed(a) < feds_pkg::OUT_MIN) sat_out = feds_pkg::OUT_MIN[39:0];
      else                                     sat_out = a[39:0];
   endfunction

   // multiplier operand selection
   always_comb begin
      mul_state = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_KIN: begin
            mul_a = 64'(feds_pkg::mag32(job_ff.spd[lane_ff]));
            mul_b = 64'(feds_pkg::mag32(job_ff.spd[lane_ff]));
         end
         ST_GRD1: begin
            mul_a = 64'(feds_pkg::mag_diff(job_ff.next[lane_ff], job_ff.prev[lane_ff]));
            mul_b = 64'(cfg.inv);
         end
         ST_GRD2: begin
            mul_a = tmp_ff;
            mul_b = tmp_ff;
         end
         ST_MAS1: begin
            mul_a = 64'(feds_pkg::mag32(job_ff.cen[lane_ff]));
            mul_b = 64'(feds_pkg::mag32(job_ff.cen[lane_ff]));
         end
         ST_MAS2: begin
            mul_a = 64'(cfg.mass);
            mul_b = tmp_ff;
         end
         ST_P1: begin
            mul_a = 64'(feds_pkg::mag32(job_ff.cen[0]));
            mul_b = 64'(feds_pkg::mag32(job_ff.cen[1]));
         end
         ST_P2: begin
            mul_a = tmp_ff;
            mul_b = 64'(feds_pkg::mag32(job_ff.cen[2]));
         end
         ST_P3: begin
            mul_a = tmp_ff;
            mul_b = tmp_ff;
         end
         ST_P4: begin
            mul_a = 64'(cfg.kappa);
            mul_b = s_ff;
         end
         ST_P5: begin
            mul_a = 64'(feds_pkg::mag32(cfg.mu));
            mul_b = s_ff;
         end
         default: mul_state = 1'b0;
      endcase
   end

   assign mul_start = mul_state && !wait_ff;
   assign div_start = (state_ff == ST_DIV) && !wait_ff;
   assign out_free  = !vld_ff || rsp_tready;
   assign q_lim     = (quo > feds_pkg::TERM_LIM) ? feds_pkg::TERM_LIM : quo;

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      lane_in  = lane_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      s_in     = s_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      wait_in  = wait_ff;
      vld_in   = vld_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;

      if (mul_state) begin
         if (!wait_ff) wait_in = 1'b1;
         else if (mul_done) begin
            wait_in = 1'b0;
            unique case (state_ff)
               ST_KIN: begin
                  acc_in   = acc_ff + feds_pkg::shr_sat(prod, FRAC_BITS + 1,
                                                        feds_pkg::TERM_LIM);
                  state_in = ST_GRD1;
               end
               ST_GRD1: begin
                  tmp_in   = feds_pkg::shr_sat(prod, FRAC_BITS, feds_pkg::ALL_ONES);
                  state_in = ST_GRD2;
               end
               ST_GRD2: begin
                  acc_in   = acc_ff + feds_pkg::shr_sat(prod, FRAC_BITS + 1,
                                                        feds_pkg::TERM_LIM);
                  state_in = ST_MAS1;
               end
               ST_MAS1: begin
                  tmp_in   = prod[63:0];
                  state_in = ST_MAS2;
               end
               ST_MAS2: begin
                  acc_in = acc_ff + feds_pkg::shr_sat(prod, 2 * FRAC_BITS + 1,
                                                      feds_pkg::TERM_LIM);
                  if (lane_ff == 2'd2) state_in = ST_P1;
                  else begin
                     lane_in  = lane_ff + 2'd1;
                     state_in = ST_KIN;
                  end
               end
               ST_P1: begin
                  tmp_in   = feds_pkg::shr_sat(prod, FRAC_BITS, feds_pkg::ALL_ONES);
                  state_in = ST_P2;
               end
               ST_P2: begin
                  tmp_in   = feds_pkg::shr_sat(prod, FRAC_BITS, feds_pkg::ALL_ONES);
                  state_in = ST_P3;
               end
               ST_P3: begin
                  s_in     = feds_pkg::shr_sat(prod, FRAC_BITS, feds_pkg::ALL_ONES);
                  state_in = ST_P4;
               end
               ST_P4: begin
                  den_in   = (64'd1 << FRAC_BITS)
                           + feds_pkg::shr_sat(prod, FRAC_BITS, feds_pkg::HALF_LIM);
                  state_in = ST_P5;
               end
               default: begin
                  num_in   = feds_pkg::shr_sat(prod, FRAC_BITS + 1, feds_pkg::ALL_ONES);
                  state_in = ST_DIV;
               end
            endcase
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  q_pop   = 1'b1;
                  job_in  = q_job;
                  acc_in  = '0;
                  lane_in = 2'd0;
                  if (!q_job.has_main) state_in = ST_FINAL;
                  else if (q_job.is_dens) state_in = ST_KIN;
                  else state_in = ST_MAIN;
               end
            end
            ST_DIV: begin
               if (!wait_ff) wait_in = 1'b1;
               else if (div_done) begin
                  wait_in  = 1'b0;
                  acc_in   = cfg.mu[31] ? (acc_ff - q_lim) : (acc_ff + q_lim);
                  state_in = ST_MAIN;
               end
            end
            ST_MAIN: begin
               if (out_free) begin
                  vld_in   = 1'b1;
                  data_in  = sat_out(acc_ff);
                  last_in  = 1'b0;
                  state_in = job_ff.has_final ? ST_FINAL : ST_IDLE;
               end
            end
            default: begin
               if (out_free) begin
                  vld_in   = 1'b1;
                  data_in  = '0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         vld_ff   <= vld_in;
      end
      job_ff  <= job_in;
      lane_ff <= lane_in;
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
      s_ff    <= s_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

FILE: sv/field_energy_density_stencil_unit.sv
// Energy density stencil: for an interior point the back end takes the job,
// runs twenty products on one shared 32x32 multiplier and a bit-serial divide,
// then loads the result; boundary and end-of-sweep results skip the products and
// the divide. A two-entry job queue lets points be taken while the back end works.
// Synchronous active-high reset clears the window, queue and result valid flag
// and loads the configuration defaults.

module field_energy_density_stencil_unit #(
   parameter int FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // field_one, field_two, field_three,
                                     // speed_one, speed_two, speed_three
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // energy_density
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   feds_pkg::cfg_type cfg_ff;
   feds_pkg::job_type push_job, head_job;
   logic q_full, q_push, q_valid, q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mu    <= feds_pkg::RST_POT_MU;
         cfg_ff.kappa <= feds_pkg::RST_POT_KAPPA;
         cfg_ff.mass  <= feds_pkg::RST_MASS_SQ;
         cfg_ff.inv   <= feds_pkg::RST_INV_TWO_DX;
      end else if (csr_we) begin
         unique case (csr_addr)
            feds_pkg::CSR_POT_MU:    cfg_ff.mu    <= csr_wdata;
            feds_pkg::CSR_POT_KAPPA: cfg_ff.kappa <= csr_wdata[30:0];
            feds_pkg::CSR_MASS_SQ:   cfg_ff.mass  <= csr_wdata[30:0];
            default:                 cfg_ff.inv   <= csr_wdata[30:0];
         endcase
      end
   end

   feds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   feds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   feds_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
